// ===== rtl/lso_pkg.sv =====
// ----------------------------------------------------------------------------
// lso_pkg
// Shared types and codes for the state observer.
// ----------------------------------------------------------------------------
package lso_pkg;

  typedef enum logic [1:0] {
    KIND_COEF  = 2'd0,
    KIND_STATE = 2'd1,
    KIND_STEP  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    MAT_A = 3'd0,
    MAT_B = 3'd1,
    MAT_C = 3'd2,
    MAT_D = 3'd3,
    MAT_L = 3'd4
  } mat_e;

  typedef enum logic [1:0] {
    CFG_STATES  = 2'd0,
    CFG_INPUTS  = 2'd1,
    CFG_OUTPUTS = 2'd2
  } cfg_e;

  // Phases of one sample: estimate output, then update state.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YHAT,
    ST_XNEW,
    ST_CLEAR,
    ST_OUT
  } state_e;

  // Term source of one product.
  typedef enum logic [1:0] {
    SRC_X,
    SRC_U,
    SRC_E
  } src_e;

  // Shared MAC control.
  typedef struct packed {
    logic clr;
    logic acc;
  } mac_ctl_t;

endpackage

// ===== rtl/lso_mac.sv =====
// ----------------------------------------------------------------------------
// lso_mac
// Registered 32x32 multiply with floor shift and 64-bit accumulator.
// ----------------------------------------------------------------------------
module lso_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lso_pkg::mac_ctl_t   ctl_i,
  input  logic signed [31:0]  a_i,
  input  logic signed [31:0]  b_i,
  output logic signed [63:0]  acc_o
);
  logic signed [63:0] prod_q, acc_q;
  logic               vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      acc_q <= '0;
    end else begin
      vld_q <= ctl_i.acc;
      if (ctl_i.clr) begin
        acc_q <= '0;
      end else if (vld_q) begin
        acc_q <= acc_q + (prod_q >>> FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(a_i) * 64'(b_i);
  end

  assign acc_o = acc_q;
endmodule

// ===== rtl/luenberger_state_observer_unit.sv =====
// ----------------------------------------------------------------------------
// luenberger_state_observer_unit
// Luenberger observer over one shared MAC, coefficients in a sync memory.
// ----------------------------------------------------------------------------
// A sample runs each active output row, then each of the NX state rows; the
// result beat is then held until taken. A new item is taken only while idle,
// so the block works on one item at a time.
// Reset clears control and the estimate vector and sets the counts to 4 states,
// 2 inputs and 2 outputs; the coefficient memory holds garbage until written.
module luenberger_state_observer_unit #(
  parameter int NX        = 4,
  parameter int NU        = 2,
  parameter int NY        = 2,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic [2:0]         matrix_sel_i,
  input  logic [1:0]         row_index_i,
  input  logic [1:0]         col_index_i,
  input  logic signed [31:0] write_value_i,
  input  logic signed [31:0] u_elem0_i,
  input  logic signed [31:0] u_elem1_i,
  input  logic signed [31:0] y_elem0_i,
  input  logic signed [31:0] y_elem1_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] est_state0_o,
  output logic signed [31:0] est_state1_o,
  output logic signed [31:0] est_state2_o,
  output logic signed [31:0] est_state3_o,
  output logic               saturated_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  // Memory map: A | B | C | D | L, each row-major with a fixed row stride.
  localparam int MW    = (NX > NU) ? NX : NU;
  localparam int MC    = (MW > NY) ? MW : NY;
  localparam int RB    = $clog2(NX > NY ? NX : NY) > 0 ? $clog2(NX > NY ? NX : NY) : 1;
  localparam int CB    = $clog2(MC) > 0 ? $clog2(MC) : 1;
  localparam int DEPTH = 5 << (RB + CB);
  localparam int AW    = $clog2(DEPTH);
  localparam int XB    = $clog2(NX) > 0 ? $clog2(NX) : 1;
  localparam int XCB   = $clog2(NX + 1);
  localparam int UCB   = $clog2(NU + 1);
  localparam int YCB   = $clog2(NY + 1);
  localparam int MAXT  = NX + NU + NY;
  localparam int TB    = $clog2(MAXT + 1);
  localparam logic signed [63:0] QMAX = 64'sd2147483647;
  localparam logic signed [63:0] QMIN = -64'sd2147483648;

  logic [31:0] coef_mem [DEPTH];
  logic [31:0] coef_rd_q;

  logic signed [31:0] x_q [NX];
  logic signed [31:0] xn_q [NX];
  logic signed [31:0] e_q [NY];
  logic signed [31:0] u_q [NU];
  logic signed [31:0] y_q [NY];
  logic [2:0] ns_cfg_q;
  logic [1:0] ni_cfg_q, no_cfg_q;

  lso_pkg::state_e st_q, st_d;
  logic [RB-1:0] row_q;
  logic [TB-1:0] term_q;        // issue index within the row
  logic [2:0]    drain_q;       // cycles since last issue
  logic          issuing_q;
  logic          sat_q;
  logic          mac_clr;

  // Clamp register counts.
  logic [XCB-1:0] ns;
  logic [UCB-1:0] ni;
  logic [YCB-1:0] no;
  always_comb begin
    ns = (ns_cfg_q == 3'd0) ? XCB'(1) : (32'(ns_cfg_q) > NX) ? XCB'(NX) : XCB'(ns_cfg_q);
    ni = (ni_cfg_q == 2'd0) ? UCB'(1) : (32'(ni_cfg_q) > NU) ? UCB'(NU) : UCB'(ni_cfg_q);
    no = (no_cfg_q == 2'd0) ? YCB'(1) : (32'(no_cfg_q) > NY) ? YCB'(NY) : YCB'(no_cfg_q);
  end

  // Terms per row: x then u then (update phase only) e.
  logic [TB-1:0] nterms;
  assign nterms = (st_q == lso_pkg::ST_XNEW) ? TB'(ns) + TB'(ni) + TB'(no)
                                             : TB'(ns) + TB'(ni);

  logic [TB-1:0] tcol;
  lso_pkg::src_e src;
  always_comb begin
    if (term_q < TB'(ns)) begin
      src = lso_pkg::SRC_X; tcol = term_q;
    end else if (term_q < TB'(ns) + TB'(ni)) begin
      src = lso_pkg::SRC_U; tcol = term_q - TB'(ns);
    end else begin
      src = lso_pkg::SRC_E; tcol = term_q - TB'(ns) - TB'(ni);
    end
  end

  // Coefficient address for the current term.
  logic [2:0] rd_mat;
  always_comb begin
    if (st_q == lso_pkg::ST_YHAT) begin
      rd_mat = (src == lso_pkg::SRC_X) ? 3'(lso_pkg::MAT_C) : 3'(lso_pkg::MAT_D);
    end else begin
      case (src)
        lso_pkg::SRC_X: rd_mat = 3'(lso_pkg::MAT_A);
        lso_pkg::SRC_U: rd_mat = 3'(lso_pkg::MAT_B);
        default:        rd_mat = 3'(lso_pkg::MAT_L);
      endcase
    end
  end
  logic [AW-1:0] rd_addr;
  assign rd_addr = AW'({rd_mat, row_q, tcol[CB-1:0]});

  // Operand for the term, registered to line up with the memory read.
  logic signed [31:0] opnd, opnd_q;
  always_comb begin
    case (src)
      lso_pkg::SRC_X: opnd = x_q[tcol[XB-1:0]];
      lso_pkg::SRC_U: opnd = u_q[tcol[(UCB > 1 ? UCB-1 : 1)-1:0]];
      default:        opnd = e_q[tcol[(YCB > 1 ? YCB-1 : 1)-1:0]];
    endcase
  end

  logic issue, mac_go_q;
  assign issue = issuing_q && (term_q < nterms);

  // Write decode.
  logic in_acc;
  assign in_ready_o = (st_q == lso_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  logic coef_ok;
  always_comb begin
    case (matrix_sel_i)
      lso_pkg::MAT_A: coef_ok = 32'(row_index_i) < NX && 32'(col_index_i) < NX;
      lso_pkg::MAT_B: coef_ok = 32'(row_index_i) < NX && 32'(col_index_i) < NU;
      lso_pkg::MAT_C: coef_ok = 32'(row_index_i) < NY && 32'(col_index_i) < NX;
      lso_pkg::MAT_D: coef_ok = 32'(row_index_i) < NY && 32'(col_index_i) < NU;
      lso_pkg::MAT_L: coef_ok = 32'(row_index_i) < NX && 32'(col_index_i) < NY;
      default:        coef_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && kind_i == lso_pkg::KIND_COEF && coef_ok) begin
      coef_mem[AW'({matrix_sel_i, row_index_i[RB-1:0], col_index_i[CB-1:0]})] <= write_value_i;
    end
    coef_rd_q <= coef_mem[rd_addr];
    opnd_q    <= opnd;
  end

  lso_pkg::mac_ctl_t  mac_ctl;
  assign mac_ctl = '{clr: mac_clr, acc: mac_go_q};

  logic signed [63:0] acc;
  lso_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (mac_ctl),
    .a_i   (coef_rd_q),
    .b_i   (opnd_q),
    .acc_o (acc)
  );

  // Row done once issue stops and the pipe (read, multiply, add) drains.
  logic row_done, last_row;
  assign row_done = !issuing_q && drain_q == 3'd3;
  assign last_row = (st_q == lso_pkg::ST_YHAT) ? (32'(row_q) + 1 >= 32'(no))
                                               : (32'(row_q) + 1 >= NX);

  always_comb begin
    st_d = st_q;
    case (st_q)
      lso_pkg::ST_IDLE:
        if (in_acc && kind_i == lso_pkg::KIND_STEP) st_d = lso_pkg::ST_YHAT;
      lso_pkg::ST_YHAT:
        if (row_done && last_row) st_d = lso_pkg::ST_XNEW;
      lso_pkg::ST_XNEW:
        if (row_done && last_row) st_d = lso_pkg::ST_OUT;
      lso_pkg::ST_OUT:
        if (out_ready_i) st_d = lso_pkg::ST_IDLE;
      default: st_d = lso_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mac_clr = row_done || in_acc;
  end

  logic signed [63:0] ysub, clip_acc;
  always_comb begin
    clip_acc = (acc > QMAX) ? QMAX : (acc < QMIN) ? QMIN : acc;
    ysub     = 64'(y_q[row_q[(YCB > 1 ? YCB-1 : 1)-1:0]]) - clip_acc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= lso_pkg::ST_IDLE;
      ns_cfg_q  <= 3'd4;
      ni_cfg_q  <= 2'd2;
      no_cfg_q  <= 2'd2;
      row_q     <= '0;
      term_q    <= '0;
      drain_q   <= '0;
      issuing_q <= 1'b0;
      mac_go_q  <= 1'b0;
      sat_q     <= 1'b0;
      for (int i = 0; i < NX; i++) x_q[i] <= '0;
    end else begin
      st_q     <= st_d;
      mac_go_q <= issue;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          lso_pkg::CFG_STATES:  ns_cfg_q <= cfg_data_i[2:0];
          lso_pkg::CFG_INPUTS:  ni_cfg_q <= cfg_data_i[1:0];
          lso_pkg::CFG_OUTPUTS: no_cfg_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        case (kind_i)
          lso_pkg::KIND_STATE:
            if (32'(row_index_i) < NX) x_q[row_index_i[XB-1:0]] <= write_value_i;
          lso_pkg::KIND_CLEAR:
            for (int i = 0; i < NX; i++) x_q[i] <= '0;
          lso_pkg::KIND_STEP: begin
            row_q <= '0; term_q <= '0; drain_q <= '0;
            issuing_q <= 1'b1; sat_q <= 1'b0;
          end
          default: ;
        endcase
      end else if (st_q == lso_pkg::ST_YHAT || st_q == lso_pkg::ST_XNEW) begin
        if (issuing_q) begin
          if (issue) term_q <= term_q + TB'(1);
          else begin issuing_q <= 1'b0; drain_q <= 3'd1; end
        end else if (!row_done) begin
          drain_q <= drain_q + 3'd1;
        end
        if (row_done) begin
          if (st_q == lso_pkg::ST_YHAT) begin
            e_q[row_q[(YCB > 1 ? YCB-1 : 1)-1:0]] <=
              (ysub > QMAX) ? 32'sh7fffffff : (ysub < QMIN) ? 32'sh80000000 : ysub[31:0];
          end else begin
            if (32'(row_q) < 32'(ns)) begin
              xn_q[row_q[XB-1:0]] <= clip_acc[31:0];
              if (acc != clip_acc) sat_q <= 1'b1;
            end else begin
              xn_q[row_q[XB-1:0]] <= '0;
            end
          end
          term_q    <= '0;
          drain_q   <= '0;
          // Inactive state rows run their terms as usual; their result is dropped for zero.
          issuing_q <= 1'b1;
          row_q     <= last_row ? '0 : row_q + RB'(1);
          if (st_q == lso_pkg::ST_XNEW && last_row) begin
            for (int i = 0; i < NX; i++) begin
              if (i == int'(row_q)) x_q[i] <= (32'(row_q) < 32'(ns)) ? clip_acc[31:0] : '0;
              else x_q[i] <= xn_q[i];
            end
            issuing_q <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && kind_i == lso_pkg::KIND_STEP) begin
      u_q[0] <= u_elem0_i;
      if (NU > 1) u_q[NU > 1 ? 1 : 0] <= u_elem1_i;
      for (int j = 2; j < NU; j++) u_q[j] <= '0;
      y_q[0] <= y_elem0_i;
      if (NY > 1) y_q[NY > 1 ? 1 : 0] <= y_elem1_i;
      for (int j = 2; j < NY; j++) y_q[j] <= '0;
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = (st_q == lso_pkg::ST_OUT);
  assign est_state0_o = x_q[0];
  assign est_state1_o = (NX > 1) ? x_q[NX > 1 ? 1 : 0] : '0;
  assign est_state2_o = (NX > 2) ? x_q[NX > 2 ? 2 : 0] : '0;
  assign est_state3_o = (NX > 3) ? x_q[NX > 3 ? 3 : 0] : '0;
  assign saturated_o  = sat_q;
endmodule

// ===== verif/luenberger_state_observer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luenberger_state_observer_checker
// Watches the item, result and register channels of the observer, keeps its
// own copy of coefficients, estimate and counts, and compares every result
// beat field by field with the oldest predicted state vector and saturation flag.
// ----------------------------------------------------------------------------
module luenberger_state_observer_checker
  import lso_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         kind_i,
  input  logic [2:0]         matrix_sel_i,
  input  logic [1:0]         row_index_i,
  input  logic [1:0]         col_index_i,
  input  logic signed [31:0] write_value_i,
  input  logic signed [31:0] u_elem0_i,
  input  logic signed [31:0] u_elem1_i,
  input  logic signed [31:0] y_elem0_i,
  input  logic signed [31:0] y_elem1_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] est_state0_i,
  input  logic signed [31:0] est_state1_i,
  input  logic signed [31:0] est_state2_i,
  input  logic signed [31:0] est_state3_i,
  input  logic               saturated_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic signed [31:0] s0, s1, s2, s3;
    logic               sat;
  } est_t;

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  longint a_m [4][4];
  longint b_m [4][2];
  longint c_m [2][4];
  longint d_m [2][2];
  longint l_m [2*2][2];
  longint est_x [4];
  logic [2:0] n_states;
  logic [1:0] n_inputs, n_outputs;
  est_t est_q[$];

  assign pending_o = est_q.size();

  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint clip(longint v, inout bit hit);
    if (v > QMAX) begin
      hit = 1;
      return QMAX;
    end
    if (v < QMIN) begin
      hit = 1;
      return QMIN;
    end
    return v;
  endfunction

  function automatic int count_of(int v, int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // Advance the estimate by one sample and return the expected beat.
  function automatic est_t observe_step(longint u0, longint u1, longint y0, longint y1);
    longint u[2], y[2], e[2], xn[4], acc;
    int ns, ni, no;
    bit hit, dummy;
    est_t r;
    hit = 0;
    dummy = 0;
    ns = count_of(n_states, 4);
    ni = count_of(n_inputs, 2);
    no = count_of(n_outputs, 2);
    u[0] = u0; u[1] = u1; y[0] = y0; y[1] = y1;
    e[0] = 0; e[1] = 0;
    for (int i = 0; i < no; i++) begin
      acc = 0;
      for (int j = 0; j < ns; j++) acc += qmul(c_m[i][j], est_x[j]);
      for (int j = 0; j < ni; j++) acc += qmul(d_m[i][j], u[j]);
      acc = clip(acc, dummy);
      e[i] = clip(y[i] - acc, dummy);
    end
    for (int i = 0; i < 4; i++) begin
      acc = 0;
      if (i < ns) begin
        for (int j = 0; j < ns; j++) acc += qmul(a_m[i][j], est_x[j]);
        for (int j = 0; j < ni; j++) acc += qmul(b_m[i][j], u[j]);
        for (int j = 0; j < no; j++) acc += qmul(l_m[i][j], e[j]);
        xn[i] = clip(acc, hit);
      end else begin
        xn[i] = 0;
      end
    end
    for (int i = 0; i < 4; i++) est_x[i] = xn[i];
    r.s0 = xn[0][31:0]; r.s1 = xn[1][31:0]; r.s2 = xn[2][31:0]; r.s3 = xn[3][31:0];
    r.sat = hit;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    est_t want;
    longint wv;
    if (!rst_ni) begin
      fail_count_o <= 0;
      n_states = 4;
      n_inputs = 2;
      n_outputs = 2;
      for (int i = 0; i < 4; i++) est_x[i] = 0;
      est_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_e'(cfg_index_i))
          CFG_STATES:  n_states = cfg_data_i[2:0];
          CFG_INPUTS:  n_inputs = cfg_data_i[1:0];
          CFG_OUTPUTS: n_outputs = cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        wv = write_value_i;
        case (kind_e'(kind_i))
          KIND_COEF: begin
            case (matrix_sel_i)
              MAT_A: a_m[row_index_i][col_index_i] = wv;
              MAT_B: if (col_index_i < 2) b_m[row_index_i][col_index_i] = wv;
              MAT_C: if (row_index_i < 2) c_m[row_index_i][col_index_i] = wv;
              MAT_D: if (row_index_i < 2 && col_index_i < 2)
                d_m[row_index_i][col_index_i] = wv;
              MAT_L: if (col_index_i < 2) l_m[row_index_i][col_index_i] = wv;
              default: ;
            endcase
          end
          KIND_STATE: est_x[row_index_i] = wv;
          KIND_CLEAR: for (int i = 0; i < 4; i++) est_x[i] = 0;
          default: est_q.push_back(observe_step(u_elem0_i, u_elem1_i, y_elem0_i, y_elem1_i));
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (est_q.size() == 0) begin
          $display("%0t: unexpected result beat, actual %h %h %h %h sat %b", $time,
                   est_state0_i, est_state1_i, est_state2_i, est_state3_i, saturated_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = est_q.pop_front();
          if (want != {est_state0_i, est_state1_i, est_state2_i, est_state3_i, saturated_i})
          begin
            $display("%0t: mismatch expected %h %h %h %h sat %b actual %h %h %h %h sat %b",
                     $time, want.s0, want.s1, want.s2, want.s3, want.sat, est_state0_i,
                     est_state1_i, est_state2_i, est_state3_i, saturated_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== verif/luenberger_state_observer_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luenberger_state_observer_unit_test
// Drives coefficient, state, clear and sample beats into the observer over
// several count settings, with random idling on both sides, and gives the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module luenberger_state_observer_unit_test;
  import lso_pkg::*;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid_i = 0;
  logic               in_ready_o;
  logic [1:0]         kind_i = 0;
  logic [2:0]         matrix_sel_i = 0;
  logic [1:0]         row_index_i = 0;
  logic [1:0]         col_index_i = 0;
  logic signed [31:0] write_value_i = 0;
  logic signed [31:0] u_elem0_i = 0, u_elem1_i = 0, y_elem0_i = 0, y_elem1_i = 0;
  logic               out_valid_o;
  logic               out_ready_i = 0;
  logic signed [31:0] est_state0_o, est_state1_o, est_state2_o, est_state3_o;
  logic               saturated_o;
  logic               cfg_valid_i = 0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = 0;
  logic [31:0]        cfg_data_i = 0;
  int                 fail_count, pending;

  // Receiver behaviour, set by the stimulus process.
  bit calm = 0;
  bit hold_off = 0;
  longint cycle_count = 0;

  luenberger_state_observer_unit dut (.*);

  luenberger_state_observer_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .matrix_sel_i,
    .row_index_i, .col_index_i, .write_value_i, .u_elem0_i, .u_elem1_i, .y_elem0_i,
    .y_elem1_i, .out_valid_i(out_valid_o), .out_ready_i, .est_state0_i(est_state0_o),
    .est_state1_i(est_state1_o), .est_state2_i(est_state2_o),
    .est_state3_i(est_state3_o), .saturated_i(saturated_o), .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count),
    .pending_o(pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Abort on a hung run: well above the slowest correct one.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: idle at random about 17 percent of the time, never while calm, always during hold-off.
  always @(posedge clk_i) begin
    if (hold_off) out_ready_i <= 0;
    else out_ready_i <= calm || ($urandom_range(99) >= 17);
  end

  // Random Q16.16 value, biased toward the extremes and small magnitudes.
  function automatic logic [31:0] rand_q();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom;
      default: return $signed($urandom_range(262143)) - 131072;
    endcase
  endfunction

  // Send one beat; idle first at random unless calm. Valid is left high after
  // the beat and dropped by the next idle cycle or wait.
  task automatic send(kind_e k, logic [2:0] m, logic [1:0] r, logic [1:0] c,
                      logic [31:0] wv, logic [31:0] u0, logic [31:0] u1,
                      logic [31:0] y0, logic [31:0] y1);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    kind_i <= k; matrix_sel_i <= m; row_index_i <= r; col_index_i <= c;
    write_value_i <= wv; u_elem0_i <= u0; u_elem1_i <= u1; y_elem0_i <= y0; y_elem1_i <= y1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic sample(logic [31:0] u0, logic [31:0] u1, logic [31:0] y0, logic [31:0] y1);
    send(KIND_STEP, 3'($urandom), 2'($urandom), 2'($urandom), $urandom, u0, u1, y0, y1);
  endtask

  task automatic coef(mat_e m, int r, int c, logic [31:0] v);
    send(KIND_COEF, m, 2'(r), 2'(c), v, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Fill every coefficient so no sample ever reads an unwritten entry.
  task automatic load_all(bit big);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        coef(MAT_A, r, c, big ? rand_q() : $signed($urandom_range(65535)) - 32768);
        if (c < 2) begin
          coef(MAT_B, r, c, big ? rand_q() : $signed($urandom_range(65535)) - 32768);
          coef(MAT_L, r, c, big ? rand_q() : $signed($urandom_range(65535)) - 32768);
        end
        if (r < 2) coef(MAT_C, r, c, big ? rand_q() : $signed($urandom_range(65535)) - 32768);
        if (r < 2 && c < 2)
          coef(MAT_D, r, c, big ? rand_q() : $signed($urandom_range(65535)) - 32768);
      end
  endtask

  // Drop valid, drain every result, then wait out the block's latency.
  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, logic [31:0] v);
    drain();
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
  endtask

  task automatic rand_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) sample(rand_q(), rand_q(), rand_q(), rand_q());
    else if (pick < 82) coef(mat_e'($urandom_range(4)), $urandom_range(3), $urandom_range(3),
                             $signed($urandom_range(131071)) - 65536);
    else if (pick < 90) send(KIND_STATE, 3'($urandom), 2'($urandom), 2'($urandom), rand_q(),
                             $urandom, $urandom, $urandom, $urandom);
    else if (pick < 94) send(KIND_CLEAR, 3'($urandom), 2'($urandom), 2'($urandom), $urandom,
                             $urandom, $urandom, $urandom, $urandom);
    // Bad selector: ignored by the block.
    else send(KIND_COEF, 3'(5 + $urandom_range(2)), 2'($urandom), 2'($urandom), $urandom,
              $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: full load, extremes, state writes, clear, bad writes.
    load_all(0);
    sample(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    sample(0, 0, 0, 0);
    send(KIND_STATE, MAT_A, 3, 0, 32'h7fffffff, 0, 0, 0, 0);
    send(KIND_STATE, MAT_A, 0, 0, 32'h80000000, 0, 0, 0, 0);
    coef(MAT_A, 0, 0, 32'h7fffffff);
    coef(MAT_A, 3, 3, 32'h80000000);
    sample(32'hffffffff, 1, 32'hffffffff, 1);
    send(KIND_COEF, 3'd7, 3, 3, 32'hffffffff, 0, 0, 0, 0);
    coef(MAT_D, 3, 3, 32'h12345678);
    coef(MAT_C, 2, 1, 32'h12345678);
    sample(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
    send(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    sample(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);

    // Count settings, extremes and out of range values included.
    write_reg(CFG_STATES, 0); write_reg(CFG_INPUTS, 0); write_reg(CFG_OUTPUTS, 0);
    sample(rand_q(), rand_q(), rand_q(), rand_q());
    write_reg(CFG_STATES, 7); write_reg(CFG_INPUTS, 3); write_reg(CFG_OUTPUTS, 3);
    sample(rand_q(), rand_q(), rand_q(), rand_q());

    for (int phase = 0; phase < 6; phase++) begin
      write_reg(CFG_STATES, (phase == 0) ? 32'hffffffff : $urandom_range(7));
      write_reg(CFG_INPUTS, (phase == 1) ? 32'h1 : $urandom_range(3));
      write_reg(CFG_OUTPUTS, (phase == 2) ? 32'h2 : $urandom);
      if (phase == 3) load_all(1);
      calm = (phase == 2);
      for (int n = 0; n < 260; n++) begin
        // Long receiver hold-off while beats keep coming.
        if (phase == 4 && n == 20) begin
          hold_off = 1;
          fork
            begin
              repeat (400) @(posedge clk_i);
              hold_off = 0;
            end
          join_none
        end
        // Sender pause until every result has come.
        if (n == 130) begin
          in_valid_i <= 0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
        rand_item();
      end
      calm = 0;
    end

    drain();
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== luenberger_state_observer_unit.f =====
rtl/lso_pkg.sv
rtl/lso_mac.sv
rtl/luenberger_state_observer_unit.sv
verif/luenberger_state_observer_checker.sv
verif/luenberger_state_observer_unit_test.sv
